// ----- rtl/complex_arithmetic_unit_defines.svh -----
// Assertion macros for the complex arithmetic unit checker.
// Expects clk and rst_n to be visible where the macros are used.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cau: assertion failed");

// next-cycle implication
`define CAU_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cau: assertion failed");

`endif

// ----- rtl/cau_pkg.sv -----
// Shared types and constants for the complex arithmetic unit.
// No dependencies.
`default_nettype none

package cau_pkg;

  localparam int FIELD_W        = 32;
  localparam int OP_W           = 3;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
  localparam logic [OP_W-1:0] OP_CONJ = 3'd4;
  localparam logic [OP_W-1:0] OP_MOD  = 3'd5;
  localparam logic [OP_W-1:0] OP_EQ   = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [FIELD_W-1:0] a_re;
    logic signed [FIELD_W-1:0] a_im;
    logic signed [FIELD_W-1:0] b_re;
    logic signed [FIELD_W-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] res_re;
    logic signed [FIELD_W-1:0] res_im;
    logic                      div_by_zero;
    logic                      equal;
  } cau_out_t;

endpackage

`default_nettype wire

// ----- rtl/cau_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, W+1 stages.
// Depends on cau_pkg for parameter defaults.
`default_nettype none

module cau_div import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [2*DATA_WIDTH+FRAC_BITS:0] num_i,
  input  logic [2*DATA_WIDTH-1:0]       den_i,
  output logic [DATA_WIDTH-1:0]         quo_o,
  output logic                          ovf_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int NW = 2 * W + 1 + FRAC_BITS;

  logic [PW-1:0] rem_r [0:W-1];
  logic [PW-1:0] den_r [0:W-1];
  logic [W-1:0]  low_r [0:W-1];
  logic [W-1:0]  quo_r [0:W];
  logic          ovf_r [0:W];

  logic [NW-1:0] num_hi;
  logic          ovf0;

  // quotient must fit in W bits, else flag overflow up front
  assign num_hi = num_i >> W;
  assign ovf0   = num_hi >= NW'(den_i);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= PW'(num_hi);
      den_r[0] <= den_i;
      low_r[0] <= num_i[W-1:0];
      quo_r[0] <= '0;
      ovf_r[0] <= ovf0;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [PW:0] trial;
    logic        take;

    assign trial = {rem_r[k-1], low_r[k-1][W-1]};
    assign take  = trial >= {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= {quo_r[k-1][W-2:0], take};
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? PW'(trial - {1'b0, den_r[k-1]}) : PW'(trial);
          den_r[k] <= den_r[k-1];
          low_r[k] <= low_r[k-1] << 1;
        end
      end
    end
  end

  assign quo_o = quo_r[W];
  assign ovf_o = ovf_r[W];

endmodule

`default_nettype wire

// ----- rtl/cau_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, W+1 stages.
// Depends on cau_pkg for parameter defaults.
`default_nettype none

module cau_sqrt import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [2*DATA_WIDTH-1:0]   rad_i,
  output logic [DATA_WIDTH-1:0]     root_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int RW = W + 3;

  logic [PW-1:0] rad_r  [0:W-1];
  logic [RW-1:0] rem_r  [0:W-1];
  logic [W-1:0]  root_r [0:W];

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= rad_i;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic          take;

    // bring down the next two radicand bits
    assign cur   = {rem_r[k-1][RW-3:0], rad_r[k-1][PW-1:PW-2]};
    assign trial = RW'({root_r[k-1], 2'b01});
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_r[k-1][W-2:0], take};
      end
    end

    if (k < W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? cur - trial : cur;
          rad_r[k] <= rad_r[k-1] << 2;
        end
      end
    end
  end

  assign root_o = root_r[W];

endmodule

`default_nettype wire

// ----- rtl/complex_arithmetic_unit.sv -----
// Complex ALU, signed fixed point, across DATA_WIDTH+5 register stages from the accepting
// edge to out_valid; one beat per cycle while the output is not stalled.
// Divider and square root lanes take one bit per stage.
// The whole pipeline holds while a finished result waits on out_ready.
// Synchronous reset clears the valid bits only; data registers are not reset.
// Depends on cau_pkg, cau_div, cau_sqrt.
`default_nettype none

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cau_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output cau_out_t out_data
);

  localparam int W        = DATA_WIDTH;
  localparam int F        = FRAC_BITS;
  localparam int PW       = 2 * W;
  localparam int SW       = 2 * W + 1;
  localparam int NW       = SW + F;
  localparam int LANE_LAT = W + 1;
  localparam int LAT      = W + 5;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
    logic                dz;
    logic                eq;
  } res_t;

  typedef struct packed {
    res_t dir;
    logic is_div;
    logic is_mod;
    logic neg_re;
    logic neg_im;
  } side_t;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] x);
    if (x[SW-1:W-1] == '0 || x[SW-1:W-1] == '1) begin
      return x[W-1:0];
    end
    return x[SW-1] ? WMIN : WMAX;
  endfunction

  function automatic logic signed [W-1:0] div_sat(input logic [W-1:0] q, input logic ovf,
                                                  input logic neg);
    if (neg) begin
      if (ovf || (q[W-1] && |q[W-2:0])) begin
        return WMIN;
      end
      return (~q) + W'(1);
    end
    if (ovf || q[W-1]) begin
      return WMAX;
    end
    return q;
  endfunction

  logic en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage 1: products and the simple operations
  logic signed [W-1:0] in_ar, in_ai, in_br, in_bi;
  res_t dir1;

  assign in_ar = W'(in_data.a_re);
  assign in_ai = W'(in_data.a_im);
  assign in_br = W'(in_data.b_re);
  assign in_bi = W'(in_data.b_im);

  always_comb begin
    dir1 = '0;
    unique case (in_data.operation)
      OP_ADD: begin
        dir1.re = sat_w(SW'(in_ar) + SW'(in_br));
        dir1.im = sat_w(SW'(in_ai) + SW'(in_bi));
      end
      OP_SUB: begin
        dir1.re = sat_w(SW'(in_ar) - SW'(in_br));
        dir1.im = sat_w(SW'(in_ai) - SW'(in_bi));
      end
      OP_CONJ: begin
        dir1.re = in_ar;
        dir1.im = sat_w(-(SW'(in_ai)));
      end
      OP_EQ: begin
        dir1.eq = (in_ar == in_br) && (in_ai == in_bi);
      end
      default: begin
      end
    endcase
  end

  logic signed [PW-1:0] s1_prr_r, s1_pii_r, s1_pri_r, s1_pir_r;
  logic signed [PW-1:0] s1_qar_r, s1_qai_r, s1_qbr_r, s1_qbi_r;
  logic [OP_W-1:0]      s1_op_r;
  logic                 s1_bz_r;
  res_t                 s1_dir_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prr_r <= PW'(in_ar) * PW'(in_br);
      s1_pii_r <= PW'(in_ai) * PW'(in_bi);
      s1_pri_r <= PW'(in_ar) * PW'(in_bi);
      s1_pir_r <= PW'(in_ai) * PW'(in_br);
      s1_qar_r <= PW'(in_ar) * PW'(in_ar);
      s1_qai_r <= PW'(in_ai) * PW'(in_ai);
      s1_qbr_r <= PW'(in_br) * PW'(in_br);
      s1_qbi_r <= PW'(in_bi) * PW'(in_bi);
      s1_op_r  <= in_data.operation;
      s1_bz_r  <= (in_br == '0) && (in_bi == '0);
      s1_dir_r <= dir1;
    end
  end

  // stage 2: sums of products
  logic signed [SW-1:0] s2_mre_r, s2_mim_r, s2_nre_r, s2_nim_r;
  logic [PW-1:0]        s2_den_r, s2_ssq_r;
  logic [OP_W-1:0]      s2_op_r;
  logic                 s2_bz_r;
  res_t                 s2_dir_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mre_r <= SW'(s1_prr_r) - SW'(s1_pii_r);
      s2_mim_r <= SW'(s1_pri_r) + SW'(s1_pir_r);
      s2_nre_r <= SW'(s1_prr_r) + SW'(s1_pii_r);
      s2_nim_r <= SW'(s1_pir_r) - SW'(s1_pri_r);
      s2_den_r <= $unsigned(s1_qbr_r) + $unsigned(s1_qbi_r);
      s2_ssq_r <= $unsigned(s1_qar_r) + $unsigned(s1_qai_r);
      s2_op_r  <= s1_op_r;
      s2_bz_r  <= s1_bz_r;
      s2_dir_r <= s1_dir_r;
    end
  end

  // stage 3: finish multiply, set up divide and square root operands
  side_t         side3;
  logic [SW-1:0] mag_re, mag_im;

  assign mag_re = s2_nre_r[SW-1] ? $unsigned(-s2_nre_r) : $unsigned(s2_nre_r);
  assign mag_im = s2_nim_r[SW-1] ? $unsigned(-s2_nim_r) : $unsigned(s2_nim_r);

  always_comb begin
    side3        = '0;
    side3.dir    = s2_dir_r;
    side3.neg_re = s2_nre_r[SW-1];
    side3.neg_im = s2_nim_r[SW-1];
    unique case (s2_op_r)
      OP_MUL: begin
        side3.dir.re = sat_w(s2_mre_r >>> F);
        side3.dir.im = sat_w(s2_mim_r >>> F);
      end
      OP_DIV: begin
        side3.dir.dz = s2_bz_r;
        side3.is_div = !s2_bz_r;
      end
      OP_MOD: begin
        side3.is_mod = 1'b1;
      end
      default: begin
      end
    endcase
  end

  logic [NW-1:0] s3_nre_r, s3_nim_r;
  logic [PW-1:0] s3_den_r, s3_ssq_r;
  side_t         s3_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_nre_r  <= NW'(mag_re) << F;
      s3_nim_r  <= NW'(mag_im) << F;
      s3_den_r  <= s2_den_r;
      s3_ssq_r  <= s2_ssq_r;
      s3_side_r <= side3;
    end
  end

  // divider and square root lanes
  logic [W-1:0] quo_re, quo_im, root;
  logic         ovf_re, ovf_im;

  cau_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_div_re (
    .clk   (clk),
    .en    (en),
    .num_i (s3_nre_r),
    .den_i (s3_den_r),
    .quo_o (quo_re),
    .ovf_o (ovf_re)
  );

  cau_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_div_im (
    .clk   (clk),
    .en    (en),
    .num_i (s3_nim_r),
    .den_i (s3_den_r),
    .quo_o (quo_im),
    .ovf_o (ovf_im)
  );

  cau_sqrt #(.DATA_WIDTH(W)) u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  (s3_ssq_r),
    .root_o (root)
  );

  side_t side_r [0:LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= s3_side_r;
      for (int i = 1; i < LANE_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // output stage
  side_t    side_end;
  res_t     fin;
  cau_out_t out_r;

  assign side_end = side_r[LANE_LAT-1];

  always_comb begin
    fin = side_end.dir;
    if (side_end.is_div) begin
      fin.re = div_sat(quo_re, ovf_re, side_end.neg_re);
      fin.im = div_sat(quo_im, ovf_im, side_end.neg_im);
    end else if (side_end.is_mod) begin
      fin.re = root[W-1] ? WMAX : root;
      fin.im = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.res_re      <= FIELD_W'(fin.re);
      out_r.res_im      <= FIELD_W'(fin.im);
      out_r.div_by_zero <= fin.dz;
      out_r.equal       <= fin.eq;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ----- rtl/cau_checker.sv -----
// Port-level checks for complex_arithmetic_unit, bound to the top level.
// Depends on cau_pkg and complex_arithmetic_unit_defines.svh.
`default_nettype none
`include "complex_arithmetic_unit_defines.svh"

module cau_checker import cau_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input cau_out_t out_data
);

  // a stalled result beat holds
  `CAU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // input side never blocks while the output can drain
  `CAU_ASSERT_IMP(a_in_ready, !out_valid || out_ready, in_ready)

  // zero denominator forces a zero result and no equal flag
  `CAU_ASSERT_IMP(a_dz_zero, out_valid && out_data.div_by_zero,
                  out_data.res_re == 0 && out_data.res_im == 0 && !out_data.equal)

  // equality test carries no numeric result
  `CAU_ASSERT_IMP(a_eq_zero, out_valid && out_data.equal,
                  out_data.res_re == 0 && out_data.res_im == 0)

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

`default_nettype wire

// ----- dv/complex_arithmetic_unit_checker.sv -----
// Checker for the complex arithmetic unit: watches both channels, predicts each
// result in Q16.16 and compares it field by field. Depends on cau_pkg.
module complex_arithmetic_unit_checker import cau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  cau_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  cau_out_t out_data,
  output int       fail_count,
  output int       pending
);

  localparam logic signed [31:0] MAX_Q = 32'sh7fffffff;
  localparam logic signed [31:0] MIN_Q = 32'sh80000000;

  cau_out_t results_due[$];

  function automatic logic signed [31:0] clamp(logic signed [127:0] v);
    if (v > 128'sd2147483647) return MAX_Q;
    if (v < -128'sd2147483648) return MIN_Q;
    return v[31:0];
  endfunction

  // quotient of n * 2^16 by den, truncated toward zero
  function automatic logic signed [31:0] div_lane(logic signed [127:0] n,
                                                  logic [127:0] den);
    logic [127:0] m;
    logic [127:0] q;
    m = n[127] ? -n : n;
    q = (m << 16) / den;
    return clamp(n[127] ? -$signed(q) : $signed(q));
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic cau_out_t alu_result(cau_in_t it);
    cau_out_t r;
    logic signed [127:0] ar, ai, br, bi, den;
    r = '0;
    ar = it.a_re; ai = it.a_im; br = it.b_re; bi = it.b_im;
    case (it.operation)
      OP_ADD: begin
        r.res_re = clamp(ar + br);
        r.res_im = clamp(ai + bi);
      end
      OP_SUB: begin
        r.res_re = clamp(ar - br);
        r.res_im = clamp(ai - bi);
      end
      OP_MUL: begin
        r.res_re = clamp((ar * br - ai * bi) >>> 16);
        r.res_im = clamp((ar * bi + ai * br) >>> 16);
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          den = br * br + bi * bi;
          r.res_re = div_lane(ar * br + ai * bi, den);
          r.res_im = div_lane(ai * br - ar * bi, den);
        end
      end
      OP_CONJ: begin
        r.res_re = it.a_re;
        r.res_im = clamp(-ai);
      end
      OP_MOD: begin
        den = ar * ar + ai * ai;
        r.res_re = clamp($signed({64'd0, root_floor(den[63:0])}));
      end
      OP_EQ: r.equal = (it.a_re == it.b_re) && (it.a_im == it.b_im);
      default: ;
    endcase
    return r;
  endfunction

  assign pending = results_due.size();

  always @(posedge clk) begin
    cau_out_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) results_due.push_back(alu_result(in_data));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result beat with nothing expected: %h", out_data);
          errs++;
        end else begin
          want = results_due.pop_front();
          if (want.res_re !== out_data.res_re) begin
            $error("res_re exp %h got %h", want.res_re, out_data.res_re);
            errs++;
          end
          if (want.res_im !== out_data.res_im) begin
            $error("res_im exp %h got %h", want.res_im, out_data.res_im);
            errs++;
          end
          if (want.div_by_zero !== out_data.div_by_zero) begin
            $error("div_by_zero exp %b got %b", want.div_by_zero, out_data.div_by_zero);
            errs++;
          end
          if (want.equal !== out_data.equal) begin
            $error("equal exp %b got %b", want.equal, out_data.equal);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ----- dv/complex_arithmetic_unit_tb.sv -----
// Testbench top for the complex arithmetic unit: drives operand beats with random
// gaps and output stalls. Depends on cau_pkg, the RTL and the checker.
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  cau_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cau_out_t out_data;
  int       fail_count;
  int       pending;
  bit       stim_done = 1'b0;

  always #5 clk = ~clk;

  complex_arithmetic_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  complex_arithmetic_unit_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'(int'($urandom_range(0, 8)) - 4) << 16;
      4: return 32'(int'($urandom_range(0, 2000)) - 1000);
      5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // one beat: optional gap, then hold valid until accepted
  task automatic send_beat(cau_in_t it, bit gaps);
    int gap;
    gap = gaps ? ($urandom_range(0, 1) ? 0 : $urandom_range(0, 5)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_ops(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
                          logic [31:0] br, logic [31:0] bi);
    cau_in_t it;
    it.operation = op; it.a_re = ar; it.a_im = ai; it.b_re = br; it.b_im = bi;
    send_beat(it, 1'b0);
  endtask

  // receiver stalls: random length before each result beat, some stretches always ready
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 3) == 0) stall = 0;
      else stall = $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  initial begin
    cau_in_t it;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_ops(OP_ADD,  32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff);
    send_ops(OP_SUB,  32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
    send_ops(OP_MUL,  32'h00018000, 32'hfffe0000, 32'h00020000, 32'h00008000);
    send_ops(OP_MUL,  32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_ops(OP_MUL,  32'hffffffff, 32'h0, 32'h00000001, 32'h0);
    send_ops(OP_DIV,  32'h00030000, 32'h00010000, 32'h0, 32'h0);
    send_ops(OP_DIV,  32'h00030000, 32'hfffe0000, 32'h00010000, 32'h00020000);
    send_ops(OP_DIV,  32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0);
    send_ops(OP_DIV,  32'hffffffff, 32'h0, 32'h00030000, 32'h0);
    send_ops(OP_CONJ, 32'h12345678, 32'h80000000, 32'hffffffff, 32'h1);
    send_ops(OP_CONJ, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
    send_ops(OP_MOD,  32'h00030000, 32'h00040000, 32'h1, 32'h2);
    send_ops(OP_MOD,  32'h80000000, 32'h80000000, 32'h0, 32'h0);
    send_ops(OP_MOD,  32'h7fffffff, 32'h0, 32'h0, 32'h0);
    send_ops(OP_EQ,   32'h00010000, 32'hffff0000, 32'h00010000, 32'hffff0000);
    send_ops(OP_EQ,   32'h00010000, 32'hffff0000, 32'h00010000, 32'hffff0001);
    send_ops(3'd7,    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    for (int n = 0; n < 1450; n++) begin
      // drain once midway
      if (n == 700) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      it.operation = 3'($urandom_range(0, 7));
      it.a_re = pick_value();
      it.a_im = pick_value();
      it.b_re = pick_value();
      it.b_im = pick_value();
      if (it.operation == OP_EQ && $urandom_range(0, 1)) begin
        it.b_re = it.a_re;
        if ($urandom_range(0, 2) != 0) it.b_im = it.a_im;
      end
      if (it.operation == OP_DIV && $urandom_range(0, 7) == 0) begin
        it.b_re = '0; it.b_im = '0;
      end
      send_beat(it, n >= 300 && n < 1200);
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    stim_done = 1'b1;
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    if (!stim_done) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/cau_sqrt.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
dv/complex_arithmetic_unit_checker.sv
dv/complex_arithmetic_unit_tb.sv
